>>> rtl/core/xvbp_pkg.sv
package xvbp_pkg;

    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned STRLEN_W  = 32;
    localparam int unsigned PAYLOAD_W = 79;   // tag, flag, two 6-bit fields, 64 value bits
    localparam int unsigned STREAM_W  = 88;   // room for eleven bytes
    localparam int unsigned LEN_W     = 7;
    localparam int unsigned NBYTES_W  = 4;

    localparam logic [1:0] KIND_DOUBLE  = 2'd0;
    localparam logic [1:0] KIND_INTEGER = 2'd1;
    localparam logic [1:0] KIND_STRING  = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [VALUE_W-1:0]  value_bits;
        logic [STRLEN_W-1:0] string_length;
        logic                end_of_block;
    } item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] prev_float_bits;
        logic [VALUE_W-1:0] prev_integer;
        logic               first_pending;
        logic [7:0]         partial_byte;
        logic [2:0]         partial_count;
    } state_t;

    typedef struct packed {
        logic [STREAM_W-1:0] stream;
        logic [NBYTES_W-1:0] nbytes;
        logic                end_of_block;
    } load_t;

endpackage

>>> rtl/core/xvbp_in_if.sv
interface xvbp_in_if;
    import xvbp_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [VALUE_W-1:0]  value_bits;
    logic [STRLEN_W-1:0] string_length;
    logic                end_of_block;

    modport source (output valid, kind, value_bits, string_length, end_of_block, input ready);
    modport sink   (input valid, kind, value_bits, string_length, end_of_block, output ready);
endinterface

>>> rtl/core/xvbp_out_if.sv
interface xvbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       block_done;

    modport source (output valid, out_byte, run_last, block_done, input ready);
    modport sink   (input valid, out_byte, run_last, block_done, output ready);
endinterface

>>> rtl/core/xvbp_encoder.sv
module xvbp_encoder (
    input  xvbp_pkg::item_t  item,
    input  xvbp_pkg::state_t state,
    output xvbp_pkg::load_t  load,
    output xvbp_pkg::state_t next_state
);
    import xvbp_pkg::*;

    function automatic logic [3:0] clz8(input logic [7:0] x);
        logic [3:0] n;
        logic       found;
        n     = 4'd8;
        found = 1'b0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!found && x[i])
            begin
                n     = 4'(7 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Leading zeros of a 64-bit word: per-byte counts, then the first non-zero byte wins.
    function automatic logic [6:0] clz64(input logic [63:0] x);
        logic [6:0] n;
        logic [3:0] sub;
        n = 7'd64;
        for (int b = 7; b >= 0; b--)
        begin
            sub = clz8(x[63 - 8*b -: 8]);
            if (x[63 - 8*b -: 8] != 8'd0)
            begin
                n = 7'(8*b) + 7'(sub);
            end
        end
        return n;
    endfunction

    function automatic logic [63:0] reverse64(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++)
        begin
            r[i] = x[63 - i];
        end
        return r;
    endfunction

    logic [VALUE_W-1:0]   xor_val;
    logic [6:0]           lead;
    logic [6:0]           trail;
    logic [6:0]           mlen;
    logic [VALUE_W-1:0]   mbits;
    logic [PAYLOAD_W-1:0] payload;
    logic [LEN_W-1:0]     len;
    logic [LEN_W-1:0]     total;
    logic [STREAM_W-1:0]  stream;
    logic [3:0]           full;

    assign xor_val = item.value_bits ^
                     ((item.kind == KIND_INTEGER) ? state.prev_integer : state.prev_float_bits);
    assign lead  = clz64(xor_val);
    assign trail = clz64(reverse64(xor_val));
    assign mlen  = 7'd64 - lead - trail;
    assign mbits = xor_val >> trail;

    always_comb
    begin
        payload    = '0;
        len        = '0;
        next_state = state;
        unique case (item.kind)
            KIND_DOUBLE, KIND_INTEGER:
            begin
                // Tag is written high bit first: its high bit lands at stream bit 0.
                payload[1] = (item.kind == KIND_INTEGER);
                next_state.first_pending = 1'b0;
                if (item.kind == KIND_INTEGER)
                begin
                    next_state.prev_integer = item.value_bits;
                end
                else
                begin
                    next_state.prev_float_bits = item.value_bits;
                end
                if (state.first_pending)
                begin
                    payload[65:2] = item.value_bits;
                    len           = 7'd66;
                    if (item.kind == KIND_INTEGER)
                    begin
                        next_state.prev_float_bits = '0;
                    end
                    else
                    begin
                        next_state.prev_integer = '0;
                    end
                end
                else if (xor_val == '0)
                begin
                    len = 7'd3;
                end
                else
                begin
                    payload[2]     = 1'b1;
                    payload[8:3]   = lead[5:0];
                    payload[14:9]  = mlen[5:0];
                    payload[78:15] = mbits;
                    len            = 7'd15 + mlen;
                end
            end
            KIND_STRING:
            begin
                payload[0]    = 1'b1;
                payload[33:2] = item.string_length;
                len           = 7'd34;
                if (state.first_pending)
                begin
                    next_state.prev_float_bits = '0;
                    next_state.prev_integer    = '0;
                    next_state.first_pending   = 1'b0;
                end
            end
            default:
            begin
                len = '0;
            end
        endcase

        // Bits of the partial byte above its count are always zero, so a plain OR merges.
        stream = (STREAM_W'(payload) << state.partial_count) | STREAM_W'(state.partial_byte);
        total  = LEN_W'(state.partial_count) + len;
        full   = total[6:3];

        next_state.partial_byte  = 8'(stream >> {full, 3'b000});
        next_state.partial_count = total[2:0];

        if (item.end_of_block)
        begin
            next_state.prev_float_bits = '0;
            next_state.prev_integer    = '0;
            next_state.first_pending   = 1'b1;
            next_state.partial_byte    = '0;
            next_state.partial_count   = '0;
        end

        load.stream       = stream;
        load.nbytes       = full + NBYTES_W'(item.end_of_block && (total[2:0] != 3'd0));
        load.end_of_block = item.end_of_block;
    end

endmodule

>>> rtl/core/xvbp_drain.sv
module xvbp_drain (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load_en,
    input  xvbp_pkg::load_t load,
    output logic            can_load,
    xvbp_out_if.source      stream_ch
);
    import xvbp_pkg::*;

    logic [STREAM_W-1:0] buf_reg;
    logic [STREAM_W-1:0] buf_next;
    logic [NBYTES_W-1:0] cnt_reg;
    logic [NBYTES_W-1:0] cnt_next;
    logic                eob_reg;
    logic                eob_next;
    logic                pop;

    assign pop      = stream_ch.valid && stream_ch.ready;
    assign can_load = (cnt_reg == '0) || ((cnt_reg == NBYTES_W'(1)) && stream_ch.ready);

    assign stream_ch.valid      = (cnt_reg != '0);
    assign stream_ch.out_byte   = buf_reg[7:0];
    assign stream_ch.run_last   = (cnt_reg == NBYTES_W'(1));
    assign stream_ch.block_done = (cnt_reg == NBYTES_W'(1)) && eob_reg;

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        eob_next = eob_reg;
        if (load_en)
        begin
            buf_next = load.stream;
            cnt_next = load.nbytes;
            eob_next = load.end_of_block;
        end
        else if (pop)
        begin
            buf_next = buf_reg >> 8;
            cnt_next = cnt_reg - NBYTES_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            eob_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            eob_reg <= eob_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

>>> rtl/core/xor_value_bit_packer_unit.sv
// Channel    Dir  Word
// value_ch   in   kind, value_bits, string_length, end_of_block
// stream_ch  out  out_byte, run_last, block_done
//
// One value word is encoded in a single pass between the input register and an
// eleven-byte output buffer, which then drains one byte per cycle while stream_ch is ready. A word
// yields up to 10 bytes, or 11 when it also flushes a partial byte.
// Words producing no byte pass through without waiting for the buffer.
// Reset (asynchronous, active low) empties both registers and restarts the block.
// A stalled output holds the buffer; one further word waits in the input register.
module xor_value_bit_packer_unit (
    input  logic       clk,
    input  logic       rst_n,
    xvbp_in_if.sink    value_ch,
    xvbp_out_if.source stream_ch
);
    import xvbp_pkg::*;

    item_t  item_reg;
    logic   hold_reg;
    state_t state_reg;
    state_t state_next;
    load_t  load;
    logic   can_load;
    logic   advance;

    xvbp_encoder u_encoder (
        .item       (item_reg),
        .state      (state_reg),
        .load       (load),
        .next_state (state_next)
    );

    assign advance        = hold_reg && (can_load || (load.nbytes == '0));
    assign value_ch.ready = !hold_reg || advance;

    xvbp_drain u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_en   (advance && (load.nbytes != '0)),
        .load      (load),
        .can_load  (can_load),
        .stream_ch (stream_ch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg                  <= 1'b0;
            state_reg.prev_float_bits <= '0;
            state_reg.prev_integer    <= '0;
            state_reg.first_pending   <= 1'b1;
            state_reg.partial_byte    <= '0;
            state_reg.partial_count   <= '0;
        end
        else
        begin
            if (value_ch.ready)
            begin
                hold_reg <= value_ch.valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (value_ch.ready && value_ch.valid)
        begin
            item_reg.kind          <= value_ch.kind;
            item_reg.value_bits    <= value_ch.value_bits;
            item_reg.string_length <= value_ch.string_length;
            item_reg.end_of_block  <= value_ch.end_of_block;
        end
    end

endmodule

>>> rtl/core/xvbp_checker.sv
module xvbp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       block_done
);

    // The final byte of a block is always the last byte of its word.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && block_done |-> run_last)
        else $error("block_done without run_last");

    // A byte that is not the last of its word is always followed by another.
    a_word_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |=> out_valid)
        else $error("word ended without run_last");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(out_byte) && $stable(run_last) && $stable(block_done))
        else $error("output word changed while stalled");

endmodule

bind xor_value_bit_packer_unit xvbp_checker u_xvbp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (stream_ch.valid),
    .out_ready  (stream_ch.ready),
    .out_byte   (stream_ch.out_byte),
    .run_last   (stream_ch.run_last),
    .block_done (stream_ch.block_done)
);

>>> tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xvbp_pkg::*;

    localparam logic [1:0] KIND_NONE      = 2'd3;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         HOLD_AFTER     = 90;
    localparam int         HOLD_CYCLES    = 220;
    localparam int         RANDOM_VALUES  = 390;
    localparam int         DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       block_done;
    } stream_byte_t;

    // Tracks the packed byte stream that each accepted value word should produce.
    class packer_scoreboard;
        stream_byte_t pending_bytes[$];
        logic [7:0]   word_out[$];
        logic [63:0]  last_double;
        logic [63:0]  last_integer;
        bit           block_fresh;
        logic [7:0]   fill_byte;
        int           fill_count;
        int           failures;
        int           mismatches;

        function new();
            restart();
            failures   = 0;
            mismatches = 0;
        endfunction

        function void restart();
            last_double  = '0;
            last_integer = '0;
            block_fresh  = 1'b1;
            fill_byte    = '0;
            fill_count   = 0;
        endfunction

        function void shift_in(bit b);
            if (b)
                fill_byte[fill_count] = 1'b1;
            fill_count++;
            if (fill_count == 8)
            begin
                word_out   = {word_out, fill_byte};
                fill_byte  = '0;
                fill_count = 0;
            end
        endfunction

        function void shift_field(logic [63:0] v, int n);
            for (int i = 0; i < n; i++)
                shift_in(v[i]);
        endfunction

        // A zero difference is one clear bit; otherwise the window around the
        // changed bits is sent with its position and width (a width of 64 wraps to 0).
        function void shift_delta(logic [63:0] x);
            int lead;
            int trail;
            int width;
            if (x == '0)
            begin
                shift_in(1'b0);
                return;
            end
            shift_in(1'b1);
            lead = 0;
            while (!x[63 - lead])
                lead++;
            trail = 0;
            while (!x[trail])
                trail++;
            width = 64 - lead - trail;
            shift_field(64'(lead), 6);
            shift_field(64'(width % 64), 6);
            shift_field(x >> trail, width);
        endfunction

        function void note_value(item_t w);
            stream_byte_t b;
            word_out.delete();
            case (w.kind)
                KIND_DOUBLE:
                begin
                    shift_in(1'b0);
                    shift_in(1'b0);
                    if (block_fresh)
                    begin
                        shift_field(w.value_bits, 64);
                        last_integer = '0;
                        block_fresh  = 1'b0;
                    end
                    else
                        shift_delta(w.value_bits ^ last_double);
                    last_double = w.value_bits;
                end
                KIND_INTEGER:
                begin
                    shift_in(1'b0);
                    shift_in(1'b1);
                    if (block_fresh)
                    begin
                        shift_field(w.value_bits, 64);
                        last_double = '0;
                        block_fresh = 1'b0;
                    end
                    else
                        shift_delta(w.value_bits ^ last_integer);
                    last_integer = w.value_bits;
                end
                KIND_STRING:
                begin
                    shift_in(1'b1);
                    shift_in(1'b0);
                    shift_field({32'b0, w.string_length}, 32);
                    if (block_fresh)
                    begin
                        last_double  = '0;
                        last_integer = '0;
                        block_fresh  = 1'b0;
                    end
                end
                default:
                    ;
            endcase
            if (w.end_of_block)
            begin
                if (fill_count != 0)
                    word_out = {word_out, fill_byte};
                restart();
            end
            for (int i = 0; i < word_out.size(); i++)
            begin
                b.data       = word_out[i];
                b.run_last   = (i == word_out.size() - 1);
                b.block_done = b.run_last && w.end_of_block;
                pending_bytes = {pending_bytes, b};
            end
        endfunction

        function void report(string msg);
            failures++;
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void check_byte(logic [7:0] data, logic run_last, logic block_done);
            stream_byte_t want;
            if (pending_bytes.size() == 0)
            begin
                report($sformatf("unexpected byte %02h last=%0b done=%0b",
                                 data, run_last, block_done));
                return;
            end
            want = pending_bytes.pop_front();
            if (want.data !== data || want.run_last !== run_last
                || want.block_done !== block_done)
                report($sformatf("byte/last/done: want %02h/%0b/%0b, got %02h/%0b/%0b",
                                 want.data, want.run_last, want.block_done,
                                 data, run_last, block_done));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    xvbp_in_if  value_if();
    xvbp_out_if stream_if();

    xor_value_bit_packer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .value_ch  (value_if),
        .stream_ch (stream_if)
    );

    packer_scoreboard board = new();
    item_t            value_plan[$];
    logic [63:0]      plan_double;
    logic [63:0]      plan_integer;
    int               values_taken;
    bit               burst;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap(int idle_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r >= idle_pct)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic add_value(logic [1:0] kind, logic [63:0] v, logic [31:0] slen, logic eob);
        item_t w;
        w.kind          = kind;
        w.value_bits    = v;
        w.string_length = slen;
        w.end_of_block  = eob;
        value_plan      = {value_plan, w};
    endtask

    // Most values differ from the previous one of their type in one window of bits,
    // so the delta encoding is exercised across all positions and widths.
    function automatic logic [63:0] next_value(logic [63:0] prev);
        logic [63:0] mask;
        int          lo;
        int          len;
        case ($urandom_range(0, 9))
            0: return prev;
            1: return rand64();
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return 64'h1;
                    default: return 64'h8000_0000_0000_0000;
                endcase
            end
            default:
            begin
                lo   = $urandom_range(0, 63);
                len  = $urandom_range(1, 64 - lo);
                mask = rand64() & (((64'd1 << len) - 64'd1) << lo);
                mask[lo]           = 1'b1;
                mask[lo + len - 1] = 1'b1;
                return prev ^ mask;
            end
        endcase
    endfunction

    task automatic plan_random();
        logic [1:0]  kind;
        logic [63:0] v;
        logic [31:0] slen;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 42)
            kind = KIND_DOUBLE;
        else if (r < 84)
            kind = KIND_INTEGER;
        else if (r < 96)
            kind = KIND_STRING;
        else
            kind = KIND_NONE;
        if (kind == KIND_DOUBLE)
        begin
            v           = next_value(plan_double);
            plan_double = v;
        end
        else if (kind == KIND_INTEGER)
        begin
            v            = next_value(plan_integer);
            plan_integer = v;
        end
        else
            v = rand64();
        case ($urandom_range(0, 5))
            0: slen = '0;
            1: slen = '1;
            default: slen = $urandom();
        endcase
        add_value(kind, v, slen, $urandom_range(0, 99) < 6);
    endtask

    task automatic plan_directed();
        add_value(KIND_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b0);
        add_value(KIND_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b0);
        add_value(KIND_DOUBLE, 64'h0, 32'h0, 1'b0);
        add_value(KIND_INTEGER, 64'h1, 32'h0, 1'b0);
        add_value(KIND_INTEGER, 64'h8000_0000_0000_0001, 32'h0, 1'b0);
        add_value(KIND_INTEGER, 64'h8000_0000_0000_0000, 32'h0, 1'b0);
        add_value(KIND_STRING, 64'h0, 32'hFFFF_FFFF, 1'b1);
        // A block that opens with a string.
        add_value(KIND_STRING, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b0);
        add_value(KIND_DOUBLE, 64'h0123_4567_89AB_CDEF, 32'h0, 1'b0);
        // The unused kind writes nothing, but its flush still acts.
        add_value(KIND_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_value(KIND_NONE, 64'h0, 32'h0, 1'b1);
        add_value(KIND_NONE, 64'h0, 32'h0, 1'b1);
        add_value(KIND_INTEGER, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0, 1'b0);
        add_value(KIND_DOUBLE, 64'h8000_0000_0000_0000, 32'h0, 1'b0);
        add_value(KIND_INTEGER, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b1);
        // Four strings fill exactly seventeen bytes, so the flush has no partial byte.
        add_value(KIND_STRING, 64'h0, 32'hA5A5_A5A5, 1'b0);
        add_value(KIND_STRING, 64'h0, 32'h5A5A_5A5A, 1'b0);
        add_value(KIND_STRING, 64'h0, 32'h0, 1'b0);
        add_value(KIND_STRING, 64'h0, 32'hFFFF_FFFF, 1'b1);
        add_value(KIND_DOUBLE, 64'h0, 32'h0, 1'b1);
    endtask

    initial
    begin : stimulus_run
        int gap;
        rst_n                  = 1'b0;
        burst                  = 1'b0;
        values_taken           = 0;
        plan_double            = '0;
        plan_integer           = '0;
        value_if.valid         = 1'b0;
        value_if.kind          = '0;
        value_if.value_bits    = '0;
        value_if.string_length = '0;
        value_if.end_of_block  = 1'b0;
        plan_directed();
        repeat (RANDOM_VALUES)
            plan_random();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        foreach (value_plan[i])
        begin
            burst = (i >= 150 && i < 230);
            gap   = burst ? 0 : pick_gap(40);
            @(negedge clk);
            if (gap > 0)
            begin
                value_if.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            value_if.kind          = value_plan[i].kind;
            value_if.value_bits    = value_plan[i].value_bits;
            value_if.string_length = value_plan[i].string_length;
            value_if.end_of_block  = value_plan[i].end_of_block;
            value_if.valid         = 1'b1;
            do
                @(posedge clk);
            while (!value_if.ready);
        end
        @(negedge clk);
        value_if.valid = 1'b0;
        while (board.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.failures == 0 && board.pending_bytes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Output side: random stalls, plus one long hold that backs the block up.
    initial
    begin : stream_receiver
        int  stall;
        bit  hold_done;
        hold_done       = 1'b0;
        stream_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && values_taken >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                stall     = HOLD_CYCLES;
            end
            else
                stall = burst ? 0 : pick_gap(30);
            if (stall > 0)
            begin
                stream_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            stream_if.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && value_if.valid && value_if.ready)
        begin
            board.note_value('{kind:          value_if.kind,
                               value_bits:    value_if.value_bits,
                               string_length: value_if.string_length,
                               end_of_block:  value_if.end_of_block});
            values_taken <= values_taken + 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && stream_if.valid && stream_if.ready)
            board.check_byte(stream_if.out_byte, stream_if.run_last, stream_if.block_done);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((value_if.valid && value_if.ready) || (stream_if.valid && stream_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

endmodule
